// ===== hdl/dofe_pkg.sv =====
// Shared types and constants for the disk occupancy FIFO evictor.
// No dependencies; imported by the top level.
`default_nettype none

package dofe_pkg;

  // Fixed field widths
  localparam int unsigned SizeW   = 31;
  localparam int unsigned TimeW   = 31;
  localparam int unsigned NrtW    = 32;
  localparam int unsigned LimitW  = 6;
  localparam int unsigned DoneW   = 7;
  localparam int unsigned TagW    = 16;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 56;

  // Configuration reset values
  localparam logic [SizeW-1:0] CapReset = 31'd1048576;
  localparam logic [SizeW-1:0] ThrReset = 31'd734003;

  typedef enum logic [CmdW-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIN   = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_STALE   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAPACITY  = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_INTERVAL  = 3'd2,
    REG_LIMIT     = 3'd3,
    REG_TAG       = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SAMPLE,
    S_FINAL,
    S_WR_CHECK,
    S_EVICT,
    S_POP,
    S_PUSH,
    S_STATUS
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/disk_occupancy_fifo_evictor.sv =====
// Top level of the disk occupancy FIFO evictor: sequencer, shared adder,
// output register. Depends on dofe_pkg and dofe_ram.
//
// Usage: one event enters per slave transaction (tuser = command, tdata =
// time and write size). The block answers with zero or more occupancy
// samples (tuser = 0) followed by one status transaction (tuser = 1, tlast
// high). Configuration must be written through cfg_we_i/cfg_idx_i/cfg_data_i
// only while the block is idle; the block itself does not enforce this.
// Timing: s_axis_tready is high only in the idle state. A plain read with no
// samples passes through the accepting idle state, a time check, a sample
// check and the status state, and the block is back in idle when its status
// is presented. Samples are issued from the sample check. A write adds a
// size check and, when stored, an append. Eviction adds a check and a pop
// per evicted size (one queue RAM read and one subtract on the shared
// adder) plus one final check, and a full queue adds a pop to force out
// its oldest size before the append. A stale event skips the sample check.
// Reset clears occupancy, queue pointers, sample state and configuration
// to its defaults; the queue RAM itself is not cleared, only entries counted
// by the queue are ever used. When the receiver stalls, the sequencer holds
// in its current state until the output register frees up.
`default_nettype none

module disk_occupancy_fifo_evictor #(
  parameter int unsigned MAX_FILES = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Slave side
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [30:0] event_time, [61:31] write_size, [63:62] zero
  input  wire logic [dofe_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: [1:0] cmd
  input  wire logic [dofe_pkg::CmdW-1:0]      s_axis_tuser,
  // Master side
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: [15:0] node_id_out, [46:16] occupancy, [48:47] status, [55:49] zero
  output logic [dofe_pkg::OutDataW-1:0]       m_axis_tdata,
  // tuser: [0] kind
  output logic                                m_axis_tuser,
  // tlast: last
  output logic                                m_axis_tlast,
  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [dofe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [dofe_pkg::SizeW-1:0]     cfg_data_i
);

  import dofe_pkg::*;

  localparam int unsigned AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int unsigned CW = $clog2(MAX_FILES + 1);
  localparam logic [CW-1:0] CountFull = CW'(MAX_FILES);
  localparam logic [AW-1:0] HeadLast  = AW'(MAX_FILES - 1);
  localparam logic [CW:0]   DepthExt  = (CW + 1)'(MAX_FILES);

  // Configuration registers
  logic [SizeW-1:0]  cap_q, thr_q, interval_q;
  logic [LimitW-1:0] limit_q;
  logic [TagW-1:0]   tag_q;

  // Architectural state
  logic [SizeW-1:0] used_q, used_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [TimeW-1:0] last_time_q, last_time_d;
  logic [NrtW-1:0]  nrt_q, nrt_d;
  logic [DoneW-1:0] done_q, done_d;

  // Current event and scratch
  state_e           state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [TimeW-1:0] time_q, time_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [SizeW-1:0] target_q, target_d;
  logic             force_q, force_d;
  status_e          stat_q, stat_d;

  // Output register
  logic             ovalid_q, ovalid_d;
  logic             okind_q, okind_d;
  logic [TagW-1:0]  otag_q, otag_d;
  logic [SizeW-1:0] oocc_q, oocc_d;
  status_e          ostat_q, ostat_d;

  // Shared adder
  logic [NrtW-1:0] alu_a, alu_b, alu_y;
  logic            alu_sub;

  // Queue RAM
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SizeW-1:0] ram_rdata;
  logic [CW:0]      pos_sum;
  logic [CW:0]      pos_wrap;

  logic             out_free;
  logic [AW-1:0]    head_inc;
  logic [DoneW-1:0] limit_ext;

  assign alu_y     = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign out_free  = !ovalid_q || m_axis_tready;
  assign head_inc  = (head_q == HeadLast) ? '0 : head_q + AW'(1);
  assign limit_ext = {1'b0, limit_q};

  // Write slot: head plus count, wrapped once
  assign pos_sum   = (CW + 1)'(head_q) + {1'b0, count_q};
  assign pos_wrap  = (pos_sum >= DepthExt) ? (pos_sum - DepthExt) : pos_sum;
  assign ram_waddr = pos_wrap[AW-1:0];

  dofe_ram #(
    .WIDTH(SizeW),
    .DEPTH(MAX_FILES)
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(size_q),
    .re_i   (1'b1),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CapReset;
      thr_q      <= ThrReset;
      interval_q <= '0;
      limit_q    <= '0;
      tag_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAPACITY:  cap_q      <= cfg_data_i;
        REG_THRESHOLD: thr_q      <= cfg_data_i;
        REG_INTERVAL:  interval_q <= cfg_data_i;
        REG_LIMIT:     limit_q    <= cfg_data_i[LimitW-1:0];
        REG_TAG:       tag_q      <= cfg_data_i[TagW-1:0];
        default: ;
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      last_time_q <= '0;
      nrt_q       <= '0;
      done_q      <= '0;
      ovalid_q    <= 1'b0;
      force_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      head_q      <= head_d;
      count_q     <= count_d;
      last_time_q <= last_time_d;
      nrt_q       <= nrt_d;
      done_q      <= done_d;
      ovalid_q    <= ovalid_d;
      force_q     <= force_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    time_q   <= time_d;
    size_q   <= size_d;
    target_q <= target_d;
    stat_q   <= stat_d;
    okind_q  <= okind_d;
    otag_q   <= otag_d;
    oocc_q   <= oocc_d;
    ostat_q  <= ostat_d;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    head_d      = head_q;
    count_d     = count_q;
    last_time_d = last_time_q;
    nrt_d       = nrt_q;
    done_d      = done_q;
    cmd_d       = cmd_q;
    time_d      = time_q;
    size_d      = size_q;
    target_d    = target_q;
    force_d     = force_q;
    stat_d      = stat_q;
    okind_d     = okind_q;
    otag_d      = otag_q;
    oocc_d      = oocc_q;
    ostat_d     = ostat_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    ram_we      = 1'b0;

    // Drop the output transaction once taken
    ovalid_d = ovalid_q && !m_axis_tready;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = cmd_e'(s_axis_tuser);
          time_d  = s_axis_tdata[TimeW-1:0];
          size_d  = s_axis_tdata[TimeW+SizeW-1:TimeW];
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        stat_d = (cmd_q == CMD_OTHER) ? ST_UNKNOWN : ST_OK;
        if (cmd_q == CMD_FIN) begin
          state_d = S_FINAL;
        end else if (time_q < last_time_q) begin
          stat_d  = ST_STALE;
          state_d = S_STATUS;
        end else begin
          last_time_d = time_q;
          state_d     = S_SAMPLE;
        end
      end

      // Timed samples; advance report time on the shared adder
      S_SAMPLE: begin
        if ({1'b0, time_q} > nrt_q && done_q < limit_ext) begin
          if (out_free) begin
            alu_a    = nrt_q;
            alu_b    = {1'b0, interval_q};
            nrt_d    = alu_y;
            done_d   = done_q + DoneW'(1);
            ovalid_d = 1'b1;
            okind_d  = 1'b0;
            otag_d   = tag_q;
            oocc_d   = used_q;
            ostat_d  = ST_OK;
          end
        end else begin
          state_d = (cmd_q == CMD_WRITE) ? S_WR_CHECK : S_STATUS;
        end
      end

      // Remaining samples at finalize
      S_FINAL: begin
        if (done_q < limit_ext + DoneW'(1)) begin
          if (out_free) begin
            done_d   = done_q + DoneW'(1);
            ovalid_d = 1'b1;
            okind_d  = 1'b0;
            otag_d   = tag_q;
            oocc_d   = used_q;
            ostat_d  = ST_OK;
          end
        end else begin
          state_d = S_STATUS;
        end
      end

      // Filter size, form capacity minus size, pick the eviction target
      S_WR_CHECK: begin
        alu_a   = {1'b0, cap_q};
        alu_b   = {1'b0, size_q};
        alu_sub = 1'b1;
        force_d = 1'b0;
        if (size_q == '0 || size_q >= cap_q) begin
          state_d = S_STATUS;
        end else begin
          target_d = (alu_y[SizeW-1:0] > thr_q) ? thr_q : alu_y[SizeW-1:0];
          // used + size > cap is the same as used > cap - size
          state_d  = (used_q > alu_y[SizeW-1:0]) ? S_EVICT : S_PUSH;
        end
      end

      // Head entry is being read every cycle; pop while above target
      S_EVICT: begin
        state_d = (used_q > target_q && count_q != '0) ? S_POP : S_PUSH;
      end

      S_POP: begin
        alu_a   = {1'b0, used_q};
        alu_b   = {1'b0, ram_rdata};
        alu_sub = 1'b1;
        used_d  = alu_y[SizeW-1:0];
        head_d  = head_inc;
        count_d = count_q - CW'(1);
        state_d = force_q ? S_PUSH : S_EVICT;
      end

      // Force out the oldest size if full, else append
      S_PUSH: begin
        if (count_q == CountFull) begin
          force_d = 1'b1;
          state_d = S_POP;
        end else begin
          alu_a   = {1'b0, used_q};
          alu_b   = {1'b0, size_q};
          used_d  = alu_y[SizeW-1:0];
          ram_we  = 1'b1;
          count_d = count_q + CW'(1);
          state_d = S_STATUS;
        end
      end

      S_STATUS: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = 1'b1;
          otag_d   = tag_q;
          oocc_d   = used_q;
          ostat_d  = stat_q;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = okind_q;
  assign m_axis_tdata  = {7'd0, ostat_q, oocc_q, otag_q};

endmodule

`default_nettype wire

// ===== hdl/dofe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dofe_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
